/* hdl/ltr_pkg.sv */
// ----------------------------------------------------------------------------
// ltr_pkg
// Shared types, character constants and the controller/datapath command and
// status records of the word tag reorder block.
// ----------------------------------------------------------------------------
package ltr_pkg;

	// Default depth of the tag store.
	localparam int TAG_DEPTH = 32;

	// Width of one code point.
	localparam int CHAR_W = 21;

	typedef logic [CHAR_W-1:0] char_t;

	// Characters with a meaning to the parser.
	localparam char_t CH_LBRACK = 21'h00005B;
	localparam char_t CH_RBRACK = 21'h00005D;
	localparam char_t CH_BSLASH = 21'h00005C;
	localparam char_t CH_CARET  = 21'h00005E;
	localparam char_t CH_DOLLAR = 21'h000024;
	localparam char_t CH_LT     = 21'h00003C;
	localparam char_t CH_HASH   = 21'h000023;
	localparam char_t CH_PLUS   = 21'h00002B;
	localparam char_t CH_SPACE  = 21'h000020;

	// Class of an incoming character.
	typedef enum logic [3:0] {
		CLS_OTHER,
		CLS_LBRACK,
		CLS_RBRACK,
		CLS_BSLASH,
		CLS_CARET,
		CLS_DOLLAR,
		CLS_LT,
		CLS_HASH,
		CLS_PLUS
	} char_cls_t;

	// Source of the character loaded into the output register.
	typedef enum logic [1:0] {
		OSRC_IN,
		OSRC_RAM,
		OSRC_DOLLAR
	} out_src_t;

	// Source of the character written into the tag store.
	typedef enum logic [1:0] {
		TSRC_IN,
		TSRC_DOLLAR,
		TSRC_SPACE,
		TSRC_CARET
	} tag_src_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      in_ready;
		logic      out_load;
		out_src_t  out_src;
		logic      out_last;
		logic      out_ovf_en;
		logic      tag_put;
		tag_src_t  tag_src;
		logic      word_clr;
		logic      rd_en;
		logic      idx_inc;
	} ltr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic      in_valid;
		logic      out_free;
		char_cls_t cls;
		logic      count_zero;
		logic      last_tag;
	} ltr_stat_t;

	// Sort a character into the classes the parser cares about.
	function automatic char_cls_t classify(char_t c);
		char_cls_t cls;
		case (c)
			CH_LBRACK: cls = CLS_LBRACK;
			CH_RBRACK: cls = CLS_RBRACK;
			CH_BSLASH: cls = CLS_BSLASH;
			CH_CARET:  cls = CLS_CARET;
			CH_DOLLAR: cls = CLS_DOLLAR;
			CH_LT:     cls = CLS_LT;
			CH_HASH:   cls = CLS_HASH;
			CH_PLUS:   cls = CLS_PLUS;
			default:   cls = CLS_OTHER;
		endcase
		return cls;
	endfunction

endpackage

/* hdl/ltr_if.sv */
// ----------------------------------------------------------------------------
// ltr_in_if / ltr_out_if
// Valid/ready channels of the word tag reorder block: the character input
// and the result output.
// ----------------------------------------------------------------------------
interface ltr_in_if;
	logic          valid;
	logic          ready;
	ltr_pkg::char_t in_char;

	modport source(output valid, output in_char, input ready);
	modport sink(input valid, input in_char, output ready);
endinterface

interface ltr_out_if;
	logic          valid;
	logic          ready;
	ltr_pkg::char_t out_char;
	logic          last;
	logic          overflow;

	modport source(output valid, output out_char, output last, output overflow, input ready);
	modport sink(input valid, input out_char, input last, input overflow, output ready);
endinterface

/* hdl/ltr_ram.sv */
// ----------------------------------------------------------------------------
// ltr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ltr_ram #(
	parameter int WIDTH = 21,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* hdl/ltr_dp.sv */
// ----------------------------------------------------------------------------
// ltr_dp
// Datapath: tag store with its fill count and overflow flag, the replay
// index, character classification and the output register.
// ----------------------------------------------------------------------------
module ltr_dp #(
	parameter int TAG_DEPTH = ltr_pkg::TAG_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ltr_pkg::ltr_cmd_t   cmd,
	output ltr_pkg::ltr_stat_t  stat,
	input  logic                in_valid,
	input  ltr_pkg::char_t      in_char,
	input  logic                out_ready,
	output logic                out_valid,
	output ltr_pkg::char_t      out_char,
	output logic                out_last,
	output logic                out_overflow
);

	localparam int IW = (TAG_DEPTH > 1) ? $clog2(TAG_DEPTH) : 1;
	localparam int CW = $clog2(TAG_DEPTH + 1);

	logic [CW-1:0]  count_q;
	logic [IW-1:0]  idx_q;
	logic           ovf_q;
	logic           out_valid_q;
	ltr_pkg::char_t out_char_q;
	logic           out_last_q;
	logic           out_ovf_q;

	logic           store_full;
	logic           wr_en;
	ltr_pkg::char_t wr_data;
	ltr_pkg::char_t rd_data;
	ltr_pkg::char_t out_char_d;

	// A tag is written only while the store has room.
	assign store_full = (count_q == CW'(TAG_DEPTH));
	assign wr_en      = cmd.tag_put && !store_full;

	// Select the character to store; a plus expands into three characters.
	always_comb begin
		case (cmd.tag_src)
			ltr_pkg::TSRC_IN:     wr_data = in_char;
			ltr_pkg::TSRC_DOLLAR: wr_data = ltr_pkg::CH_DOLLAR;
			ltr_pkg::TSRC_SPACE:  wr_data = ltr_pkg::CH_SPACE;
			ltr_pkg::TSRC_CARET:  wr_data = ltr_pkg::CH_CARET;
			default:              wr_data = in_char;
		endcase
	end

	ltr_ram #(
		.WIDTH(ltr_pkg::CHAR_W),
		.DEPTH(TAG_DEPTH)
	) u_tag_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(count_q[IW-1:0]),
		.wr_data(wr_data),
		.rd_en  (cmd.rd_en),
		.rd_addr(idx_q),
		.rd_data(rd_data)
	);

	// Fill count, overflow flag and replay index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			idx_q   <= '0;
		end else if (cmd.word_clr) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (cmd.tag_put) begin
				if (store_full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + CW'(1);
				end
			end
			if (cmd.idx_inc) begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Select the character of the next result.
	always_comb begin
		case (cmd.out_src)
			ltr_pkg::OSRC_IN:     out_char_d = in_char;
			ltr_pkg::OSRC_RAM:    out_char_d = rd_data;
			ltr_pkg::OSRC_DOLLAR: out_char_d = ltr_pkg::CH_DOLLAR;
			default:              out_char_d = in_char;
		endcase
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_char_q <= out_char_d;
			out_last_q <= cmd.out_last;
			out_ovf_q  <= cmd.out_ovf_en & ovf_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_char     = out_char_q;
	assign out_last     = out_last_q;
	assign out_overflow = out_ovf_q;

	// Status toward the controller.
	always_comb begin
		stat.in_valid   = in_valid;
		stat.out_free   = !out_valid_q || out_ready;
		stat.cls        = ltr_pkg::classify(in_char);
		stat.count_zero = (count_q == '0);
		stat.last_tag   = ((CW'(idx_q) + CW'(1)) == count_q);
	end

endmodule

/* hdl/ltr_ctrl.sv */
// ----------------------------------------------------------------------------
// ltr_ctrl
// Controller: parse mode and tag capture tracking, plus the sequencer that
// expands a captured plus and replays the tag store at the end of a word.
// ----------------------------------------------------------------------------
module ltr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  ltr_pkg::ltr_stat_t stat,
	output ltr_pkg::ltr_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PLUS_SP,
		ST_PLUS_CARET,
		ST_READ,
		ST_EMIT,
		ST_CLOSE
	} state_t;

	typedef enum logic [2:0] {
		MODE_PLAIN,
		MODE_ESC,
		MODE_BLANK,
		MODE_BLANK_ESC,
		MODE_WORD
	} mode_t;

	state_t state_q, state_d;
	mode_t  mode_q, mode_d;
	logic   cap_q, cap_d;
	logic   cap_n;

	// Capture flag as updated by the current word character.
	always_comb begin
		case (stat.cls)
			ltr_pkg::CLS_LT:   cap_n = 1'b1;
			ltr_pkg::CLS_HASH: cap_n = 1'b0;
			default:           cap_n = cap_q;
		endcase
	end

	// Next state and commands.
	always_comb begin
		cmd         = '0;
		cmd.out_src = ltr_pkg::OSRC_IN;
		cmd.tag_src = ltr_pkg::TSRC_IN;
		state_d     = state_q;
		mode_d      = mode_q;
		cap_d       = cap_q;
		case (state_q)
			ST_IDLE: begin
				cmd.in_ready = stat.out_free;
				if (stat.in_valid && stat.out_free) begin
					case (mode_q)
						MODE_ESC: begin
							cmd.out_load = 1'b1;
							cmd.out_last = 1'b1;
							mode_d       = MODE_PLAIN;
						end
						MODE_BLANK: begin
							cmd.out_load = 1'b1;
							cmd.out_last = 1'b1;
							if (stat.cls == ltr_pkg::CLS_RBRACK) begin
								mode_d = MODE_PLAIN;
							end else if (stat.cls == ltr_pkg::CLS_BSLASH) begin
								mode_d = MODE_BLANK_ESC;
							end
						end
						MODE_BLANK_ESC: begin
							cmd.out_load = 1'b1;
							cmd.out_last = 1'b1;
							mode_d       = MODE_BLANK;
						end
						MODE_WORD: begin
							if (stat.cls == ltr_pkg::CLS_DOLLAR) begin
								// Close the word: replay the tags first if any.
								if (stat.count_zero) begin
									cmd.out_load   = 1'b1;
									cmd.out_src    = ltr_pkg::OSRC_DOLLAR;
									cmd.out_last   = 1'b1;
									cmd.out_ovf_en = 1'b1;
									cmd.word_clr   = 1'b1;
									mode_d         = MODE_PLAIN;
									cap_d          = 1'b0;
								end else begin
									state_d = ST_READ;
								end
							end else begin
								cap_d = cap_n;
								if (cap_n) begin
									cmd.tag_put = 1'b1;
									if (stat.cls == ltr_pkg::CLS_PLUS) begin
										cmd.tag_src = ltr_pkg::TSRC_DOLLAR;
										state_d     = ST_PLUS_SP;
									end
								end else begin
									cmd.out_load   = 1'b1;
									cmd.out_last   = 1'b1;
									cmd.out_ovf_en = 1'b1;
								end
							end
						end
						default: begin
							cmd.out_load = 1'b1;
							cmd.out_last = 1'b1;
							case (stat.cls)
								ltr_pkg::CLS_LBRACK: mode_d = MODE_BLANK;
								ltr_pkg::CLS_BSLASH: mode_d = MODE_ESC;
								ltr_pkg::CLS_CARET: begin
									mode_d       = MODE_WORD;
									cap_d        = 1'b0;
									cmd.word_clr = 1'b1;
								end
								default: mode_d = MODE_PLAIN;
							endcase
						end
					endcase
				end
			end
			ST_PLUS_SP: begin
				cmd.tag_put = 1'b1;
				cmd.tag_src = ltr_pkg::TSRC_SPACE;
				state_d     = ST_PLUS_CARET;
			end
			ST_PLUS_CARET: begin
				cmd.tag_put = 1'b1;
				cmd.tag_src = ltr_pkg::TSRC_CARET;
				state_d     = ST_IDLE;
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_src    = ltr_pkg::OSRC_RAM;
					cmd.out_ovf_en = 1'b1;
					if (stat.last_tag) begin
						state_d = ST_CLOSE;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = ST_READ;
					end
				end
			end
			ST_CLOSE: begin
				if (stat.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_src    = ltr_pkg::OSRC_DOLLAR;
					cmd.out_last   = 1'b1;
					cmd.out_ovf_en = 1'b1;
					cmd.word_clr   = 1'b1;
					mode_d         = MODE_PLAIN;
					cap_d          = 1'b0;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State, parse mode and capture flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= MODE_PLAIN;
			cap_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			cap_q   <= cap_d;
		end
	end

endmodule

/* hdl/lexical_unit_tag_reorder.sv */
// ----------------------------------------------------------------------------
// lexical_unit_tag_reorder
// Throughput: one request per cycle while the output register has room and no
// sequence runs; a captured plus is stored as dollar, space and caret, and a closing
// dollar replays the stored tags (a RAM read and a load per tag) before the dollar.
// Reset: arst_n clears parse mode, counters and the output valid flag; the
// tag RAM is not cleared, as only written entries are ever read.
// ----------------------------------------------------------------------------
module lexical_unit_tag_reorder #(
	parameter int TAG_DEPTH = ltr_pkg::TAG_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	ltr_in_if.sink            in_ch,
	ltr_out_if.source         out_ch
);

	ltr_pkg::ltr_cmd_t  cmd;
	ltr_pkg::ltr_stat_t stat;

	// Sequencing and parse state.
	ltr_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.stat  (stat),
		.cmd   (cmd)
	);

	// Tag store and output register.
	ltr_dp #(
		.TAG_DEPTH(TAG_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_valid    (in_ch.valid),
		.in_char     (in_ch.in_char),
		.out_ready   (out_ch.ready),
		.out_valid   (out_ch.valid),
		.out_char    (out_ch.out_char),
		.out_last    (out_ch.last),
		.out_overflow(out_ch.overflow)
	);

	assign in_ch.ready = cmd.in_ready;

endmodule

/* hdl/ltr_checker.sv */
// ----------------------------------------------------------------------------
// ltr_checker
// Port-level checks of the word tag reorder block, bound to the top level.
// ----------------------------------------------------------------------------
module ltr_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_last
);

	// A pending result stays offered until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before it was taken");

	// A new request is only taken when the output register has room.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!out_valid || out_ready))
		else $error("request taken while the output register is blocked");

	// While a word is being replayed, no new request is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> !in_ready)
		else $error("request taken in the middle of a replay");

	// A request is never taken in the cycle right after a non-final result
	// was loaded.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) && !out_last |-> !(in_valid && in_ready))
		else $error("request taken while tags are still pending");

endmodule

bind lexical_unit_tag_reorder ltr_checker u_ltr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_ch.valid),
	.in_ready (in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_last (out_ch.last)
);
